// ----- sv/pdc_pkg.sv -----
`default_nettype none
package pdc_pkg;

	localparam int SUM_WIDTH = 24;
	localparam int LVL_W     = 12;
	localparam int ERR_W     = LVL_W + 1;
	localparam int DIFF_W    = ERR_W + 1;
	localparam int GAIN_W    = 16;
	localparam int LIM_W     = 10;
	localparam int DRV_W     = 7;
	localparam int FRAC_W    = 8;
	localparam int P_W       = ERR_W + GAIN_W + 1 - FRAC_W;
	localparam int D_W       = DIFF_W + GAIN_W + 1 - FRAC_W;
	localparam int I_W       = SUM_WIDTH + GAIN_W + 1 - FRAC_W;
	localparam int TOT_W     = ((I_W > D_W) ? I_W : D_W) + 2;
	localparam int DRIVE_MAX = 100;
	localparam int LIM_RESET = 100;

	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN  = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT = CFG_IDX_W'(3);

	typedef struct packed {
		logic [GAIN_W-1:0] prop_gain;
		logic [GAIN_W-1:0] integ_gain;
		logic [GAIN_W-1:0] deriv_gain;
		logic [LIM_W-1:0]  integ_limit;
	} gains_t;

endpackage
`default_nettype wire

// ----- sv/pid_duty_controller_top.sv -----
// Path: a request is taken into the input register, goes through the control
// law and waits in the output register until the receiver takes the result.
// Throughput: one request per cycle; while a result waits, one more request
// is taken into the input register, then input holds until the result goes.
// Reset: gains clear to zero, integral limit to 100, previous error and
// error accumulator to zero, and both pipeline registers empty.
`default_nettype none
module pid_duty_controller_top (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  wire logic [23:0]                     s_axis_tdata,  // target_level, measured_level
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	output logic [7:0]                           m_axis_tdata,  // drive, zero pad
	output logic                                 m_axis_tuser,  // limit_taken
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [pdc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [pdc_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int LW = pdc_pkg::LVL_W;

	pdc_pkg::gains_t gains;

	logic                                   valid_s1;
	logic [LW-1:0]                          target_s1;
	logic [LW-1:0]                          measured_s1;
	logic                                   out_valid_q;
	logic [pdc_pkg::DRV_W-1:0]              drive_q;
	logic                                   took_q;
	logic signed [pdc_pkg::ERR_W-1:0]       prev_error_q;
	logic signed [pdc_pkg::SUM_WIDTH-1:0]   error_sum_q;

	logic                                   advance;
	logic [pdc_pkg::DRV_W-1:0]              drive_c;
	logic                                   took_c;
	logic signed [pdc_pkg::ERR_W-1:0]       error_c;
	logic signed [pdc_pkg::SUM_WIDTH-1:0]   sum_c;

	pdc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.gains     (gains)
	);

	pdc_law u_law (
		.gains          (gains),
		.target_level   (target_s1),
		.measured_level (measured_s1),
		.prev_error     (prev_error_q),
		.error_sum      (error_sum_q),
		.drive          (drive_c),
		.limit_taken    (took_c),
		.error          (error_c),
		.next_sum       (sum_c)
	);

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			target_s1   <= s_axis_tdata[LW-1:0];
			measured_s1 <= s_axis_tdata[2*LW-1:LW];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			prev_error_q <= '0;
			error_sum_q  <= '0;
		end else begin
			if (advance) begin
				out_valid_q  <= 1'b1;
				prev_error_q <= error_c;
				error_sum_q  <= sum_c;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			drive_q <= drive_c;
			took_q  <= took_c;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, drive_q};
	assign m_axis_tuser  = took_q;

endmodule
`default_nettype wire

// ----- sv/pdc_cfg_regs.sv -----
`default_nettype none
module pdc_cfg_regs (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [pdc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [pdc_pkg::CFG_DATA_W-1:0]  cfg_data,
	output pdc_pkg::gains_t                      gains
);

	pdc_pkg::gains_t gains_q;

	assign cfg_ready = 1'b1;
	assign gains     = gains_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q.prop_gain   <= '0;
			gains_q.integ_gain  <= '0;
			gains_q.deriv_gain  <= '0;
			gains_q.integ_limit <= pdc_pkg::LIM_W'(pdc_pkg::LIM_RESET);
		end else if (cfg_valid) begin
			case (cfg_index)
				pdc_pkg::REG_PROP_GAIN: begin
					gains_q.prop_gain <= cfg_data[pdc_pkg::GAIN_W-1:0];
				end
				pdc_pkg::REG_INTEG_GAIN: begin
					gains_q.integ_gain <= cfg_data[pdc_pkg::GAIN_W-1:0];
				end
				pdc_pkg::REG_DERIV_GAIN: begin
					gains_q.deriv_gain <= cfg_data[pdc_pkg::GAIN_W-1:0];
				end
				pdc_pkg::REG_INTEG_LIMIT: begin
					gains_q.integ_limit <= cfg_data[pdc_pkg::LIM_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- sv/pdc_law.sv -----
`default_nettype none
module pdc_law (
	input  wire pdc_pkg::gains_t                      gains,
	input  wire logic [pdc_pkg::LVL_W-1:0]            target_level,
	input  wire logic [pdc_pkg::LVL_W-1:0]            measured_level,
	input  wire logic signed [pdc_pkg::ERR_W-1:0]     prev_error,
	input  wire logic signed [pdc_pkg::SUM_WIDTH-1:0] error_sum,
	output logic [pdc_pkg::DRV_W-1:0]                 drive,
	output logic                                      limit_taken,
	output logic signed [pdc_pkg::ERR_W-1:0]          error,
	output logic signed [pdc_pkg::SUM_WIDTH-1:0]      next_sum
);

	localparam int SW = pdc_pkg::SUM_WIDTH;
	localparam int GW = pdc_pkg::GAIN_W;
	localparam int EW = pdc_pkg::ERR_W;
	localparam int DW = pdc_pkg::DIFF_W;
	localparam int FW = pdc_pkg::FRAC_W;
	localparam int TW = pdc_pkg::TOT_W;

	logic signed [DW-1:0]    diff;
	logic signed [DW-1:0]    pair;
	logic signed [GW:0]      kp;
	logic signed [GW:0]      ki;
	logic signed [GW:0]      kd;
	logic signed [EW+GW:0]   p_prod;
	logic signed [DW+GW:0]   d_prod;
	logic signed [DW+GW:0]   t_prod;
	logic signed [SW+GW:0]   i_prod;
	logic signed [pdc_pkg::P_W-1:0] p_term;
	logic signed [pdc_pkg::D_W-1:0] d_term;
	logic signed [pdc_pkg::D_W-1:0] test;
	logic signed [pdc_pkg::I_W-1:0] i_term;
	logic signed [pdc_pkg::D_W-1:0] lim_s;
	logic signed [TW-1:0]    sel;
	logic signed [TW-1:0]    total;
	logic signed [SW:0]      wide_sum;

	assign error = $signed({1'b0, target_level}) - $signed({1'b0, measured_level});
	assign diff  = DW'(error) - DW'(prev_error);
	assign pair  = DW'(error) + DW'(prev_error);

	assign kp = $signed({1'b0, gains.prop_gain});
	assign ki = $signed({1'b0, gains.integ_gain});
	assign kd = $signed({1'b0, gains.deriv_gain});

	assign p_prod = kp * error;
	assign d_prod = kd * diff;
	assign t_prod = ki * pair;
	assign i_prod = ki * error_sum;

	assign p_term = $signed(p_prod[EW+GW:FW]);
	assign d_term = $signed(d_prod[DW+GW:FW]);
	assign test   = $signed(t_prod[DW+GW:FW]);
	assign i_term = $signed(i_prod[SW+GW:FW]);

	assign lim_s       = $signed(pdc_pkg::D_W'(gains.integ_limit));
	assign limit_taken = (test > lim_s) || (test < -lim_s);

	assign sel   = limit_taken ? TW'(lim_s) : TW'(i_term);
	assign total = TW'(p_term) + TW'(d_term) + sel;

	always_comb begin
		if (total < $signed(TW'(0))) begin
			drive = '0;
		end else if (total > $signed(TW'(pdc_pkg::DRIVE_MAX))) begin
			drive = pdc_pkg::DRV_W'(pdc_pkg::DRIVE_MAX);
		end else begin
			drive = total[pdc_pkg::DRV_W-1:0];
		end
	end

	assign wide_sum = (SW+1)'(error_sum) + (SW+1)'(error);

	always_comb begin
		if (wide_sum[SW] != wide_sum[SW-1]) begin
			next_sum = wide_sum[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
		end else begin
			next_sum = wide_sum[SW-1:0];
		end
	end

endmodule
`default_nettype wire

// ----- test/tb_pid_duty_controller_top.sv -----
`default_nettype none
module tb_pid_duty_controller_top;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [pdc_pkg::DRV_W-1:0] drive;
		logic                      limit_taken;
	} duty_t;

	localparam int     CYCLE_LIMIT = 200000;
	localparam longint ACC_MAX     = (longint'(1) <<< (pdc_pkg::SUM_WIDTH - 1)) - 1;
	localparam longint ACC_MIN     = -ACC_MAX - 1;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           s_axis_tvalid;
	logic                           s_axis_tready;
	logic [23:0]                    s_axis_tdata;   // target_level, measured_level
	logic                           m_axis_tvalid;
	logic                           m_axis_tready = 1'b0;
	logic [7:0]                     m_axis_tdata;   // drive, zero pad
	logic                           m_axis_tuser;   // limit_taken
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [pdc_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [pdc_pkg::CFG_DATA_W-1:0] cfg_data;

	pdc_pkg::gains_t                      gains_m;
	logic signed [pdc_pkg::ERR_W-1:0]     last_error;
	logic signed [pdc_pkg::SUM_WIDTH-1:0] error_acc;
	duty_t                                duty_q[$];
	int                                   fail_count = 0;
	int                                   send_idle_pct = 0;
	int                                   recv_idle_pct = 0;
	int                                   hold_cycles = 0;
	int                                   cycle_count = 0;

	pid_duty_controller_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic duty_t next_duty(input logic [pdc_pkg::LVL_W-1:0] tgt,
			input logic [pdc_pkg::LVL_W-1:0] meas);
		longint err;
		longint lim;
		longint p_term;
		longint d_term;
		longint i_test;
		longint total;
		longint acc;
		duty_t  res;
		err    = longint'(tgt) - longint'(meas);
		lim    = longint'(gains_m.integ_limit);
		p_term = (longint'(gains_m.prop_gain) * err) >>> pdc_pkg::FRAC_W;
		d_term = (longint'(gains_m.deriv_gain) * (err - longint'(last_error)))
			>>> pdc_pkg::FRAC_W;
		i_test = (longint'(gains_m.integ_gain) * (err + longint'(last_error)))
			>>> pdc_pkg::FRAC_W;
		res.limit_taken = (i_test > lim) || (i_test < -lim);
		if (res.limit_taken) begin
			total = p_term + d_term + lim;
		end else begin
			total = p_term + d_term +
				((longint'(gains_m.integ_gain) * longint'(error_acc)) >>> pdc_pkg::FRAC_W);
		end
		if (total < 0) begin
			total = 0;
		end else if (total > pdc_pkg::DRIVE_MAX) begin
			total = pdc_pkg::DRIVE_MAX;
		end
		res.drive = pdc_pkg::DRV_W'(total);
		last_error = pdc_pkg::ERR_W'(err);
		acc = longint'(error_acc) + err;
		if (acc > ACC_MAX) begin
			acc = ACC_MAX;
		end else if (acc < ACC_MIN) begin
			acc = ACC_MIN;
		end
		error_acc = pdc_pkg::SUM_WIDTH'(acc);
		return res;
	endfunction

	task automatic send_item(input logic [pdc_pkg::LVL_W-1:0] tgt,
			input logic [pdc_pkg::LVL_W-1:0] meas);
		int gap;
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {meas, tgt};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		duty_q.push_back(next_duty(tgt, meas));
		if ($urandom_range(99) < send_idle_pct) begin
			gap = $urandom_range(1, 4);
			@(negedge clk) s_axis_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic cfg_write(input logic [pdc_pkg::CFG_IDX_W-1:0] idx,
			input logic [pdc_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			pdc_pkg::REG_PROP_GAIN:   gains_m.prop_gain   = data;
			pdc_pkg::REG_INTEG_GAIN:  gains_m.integ_gain  = data;
			pdc_pkg::REG_DERIV_GAIN:  gains_m.deriv_gain  = data;
			pdc_pkg::REG_INTEG_LIMIT: gains_m.integ_limit = data[pdc_pkg::LIM_W-1:0];
			default: ;
		endcase
		@(negedge clk) cfg_valid <= 1'b0;
	endtask

	task automatic set_gains(input logic [15:0] kp, input logic [15:0] ki,
			input logic [15:0] kd, input logic [15:0] lim);
		cfg_write(pdc_pkg::REG_PROP_GAIN, kp);
		cfg_write(pdc_pkg::REG_INTEG_GAIN, ki);
		cfg_write(pdc_pkg::REG_DERIV_GAIN, kd);
		cfg_write(pdc_pkg::REG_INTEG_LIMIT, lim);
	endtask

	task automatic drain_results();
		@(negedge clk) s_axis_tvalid <= 1'b0;
		while (duty_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [15:0] rand_gain();
		case ($urandom_range(9))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			2:       return 16'($urandom);
			3, 4:    return 16'($urandom_range(0, 'h400));
			default: return 16'($urandom_range(0, 'h60));
		endcase
	endfunction

	task automatic test_reset_values();
		send_item(12'd4095, 12'd0);
		send_item(12'd0, 12'd4095);
		send_item(12'd1234, 12'd1234);
		drain_results();
	endtask

	task automatic test_register_writes();
		set_gains(16'h0100, 16'h0010, 16'h0040, 16'hFC05);
		cfg_write(8'd4, 16'hFFFF);
		cfg_write(8'hFF, 16'hFFFF);
		cfg_write(pdc_pkg::CFG_IDX_W'($urandom_range(4, 255)), 16'($urandom));
		send_item(12'd40, 12'd0);
		send_item(12'd0, 12'd30);
		send_item(12'd10, 12'd10);
		drain_results();
	endtask

	task automatic test_extremes();
		set_gains(16'h0100, 16'h0000, 16'h0000, 16'd100);
		send_item(12'd4095, 12'd0);
		send_item(12'd0, 12'd4095);
		send_item(12'd2048, 12'd2048);
		send_item(12'd50, 12'd0);
		drain_results();
		set_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_item(12'd4095, 12'd0);
		send_item(12'd0, 12'd4095);
		send_item(12'd0, 12'd0);
		send_item(12'd4095, 12'd4095);
		drain_results();
		set_gains(16'h0000, 16'h0100, 16'h0000, 16'h0000);
		send_item(12'd1, 12'd0);
		send_item(12'd0, 12'd0);
		send_item(12'd0, 12'd1);
		send_item(12'd0, 12'd0);
		drain_results();
	endtask

	task automatic test_rounding();
		set_gains(16'h0080, 16'h0100, 16'h0080, 16'h03FF);
		send_item(12'd60, 12'd0);
		send_item(12'd0, 12'd1);
		send_item(12'd0, 12'd3);
		send_item(12'd7, 12'd0);
		drain_results();
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		set_gains(16'h0040, 16'h0008, 16'h0020, 16'd50);
		@(posedge clk);
		// hold off the receiver while requests pile up
		hold_cycles = 150;
		repeat (20) send_item(12'($urandom), 12'($urandom));
		drain_results();
		repeat (10) send_item(12'($urandom), 12'($urandom));
		drain_results();
	endtask

	task automatic test_random();
		int          v;
		logic [11:0] tgt;
		logic [11:0] meas;
		logic [15:0] lim;
		for (int mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin
					send_idle_pct = 23;
					recv_idle_pct = 59;
				end
				1: begin
					send_idle_pct = 59;
					recv_idle_pct = 23;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			repeat (6) begin
				drain_results();
				case ($urandom_range(4))
					0:       lim = 16'h0000;
					1:       lim = 16'h03FF;
					2:       lim = 16'($urandom);
					default: lim = 16'($urandom_range(0, 200));
				endcase
				set_gains(rand_gain(), rand_gain(), rand_gain(), lim);
				repeat (28) begin
					tgt = 12'($urandom);
					case ($urandom_range(9))
						0, 1: meas = 12'($urandom);
						2: begin
							tgt  = $urandom_range(1) ? 12'd4095 : 12'd0;
							meas = $urandom_range(1) ? 12'd4095 : 12'd0;
						end
						default: begin
							v = $urandom_range(0, 64);
							v = int'(tgt) + v - 32;
							if (v < 0) v = 0;
							if (v > 4095) v = 4095;
							meas = 12'(v);
						end
					endcase
					send_item(tgt, meas);
				end
			end
		end
		drain_results();
	endtask

	always @(posedge clk) begin
		duty_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (duty_q.size() == 0) begin
				fail_count++;
				$error("unexpected result: drive %0d limit_taken %0d",
					m_axis_tdata[pdc_pkg::DRV_W-1:0], m_axis_tuser);
			end else begin
				want = duty_q.pop_front();
				if (m_axis_tdata[pdc_pkg::DRV_W-1:0] !== want.drive) begin
					fail_count++;
					$error("drive: expected %0d, actual %0d", want.drive,
						m_axis_tdata[pdc_pkg::DRV_W-1:0]);
				end
				if (m_axis_tuser !== want.limit_taken) begin
					fail_count++;
					$error("limit_taken: expected %0d, actual %0d", want.limit_taken,
						m_axis_tuser);
				end
			end
		end
	end

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			m_axis_tready <= 1'b0;
			hold_cycles--;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_pid_duty_controller_top: errors");
		$finish;
	end

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		gains_m       = '{prop_gain: '0, integ_gain: '0, deriv_gain: '0,
			integ_limit: pdc_pkg::LIM_W'(pdc_pkg::LIM_RESET)};
		last_error    = '0;
		error_acc     = '0;
		send_idle_pct = 23;
		recv_idle_pct = 59;
		repeat (10) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		test_reset_values();
		test_register_writes();
		test_extremes();
		test_rounding();
		test_backpressure();
		test_random();

		drain_results();
		if (duty_q.size() != 0) begin
			$error("results still outstanding: %0d", duty_q.size());
		end
		if (fail_count == 0 && duty_q.size() == 0) begin
			$display("tb_pid_duty_controller_top: clean");
		end else begin
			$display("tb_pid_duty_controller_top: errors");
		end
		$finish;
	end

endmodule
`default_nettype wire
